// ===== rtl/wbd_pkg.sv =====
`timescale 1ns / 1ps

package wbd_pkg;

  localparam int WORD_W   = 64;
  localparam int CHUNK_W  = 32;
  localparam int DIGIT_W  = 4;
  localparam int POS_W    = 6;
  localparam int DIV_W    = CHUNK_W + DIGIT_W;

  // floor(d / 10) = (d * RECIP) >> RECIP_SHIFT holds for every d below 2**38.
  localparam logic [DIV_W-1:0] RECIP       = 36'hCCCCCCCCD;
  localparam int               RECIP_SHIFT = 39;

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_start;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic pass_end;
    logic value_zero;
  } status_t;

endpackage

// ===== rtl/wbd_ctrl.sv =====
`timescale 1ns / 1ps

module wbd_ctrl
  import wbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    last_word,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    busy           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_word) begin
            cmd.conv_start = 1'b1;
            state_next     = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (status.value_zero) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/wbd_datapath.sv =====
`timescale 1ns / 1ps

module wbd_datapath
  import wbd_pkg::*;
#(
  parameter int NUM_WORDS = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [WORD_W-1:0]  word,
  output status_t            status,
  output logic               strobe,
  output logic [DIGIT_W-1:0] digit,
  output logic [POS_W-1:0]   digit_position,
  output logic               last_digit
);

  localparam int NCH = 2 * NUM_WORDS;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int WLW = $clog2(NUM_WORDS + 1);

  logic [CHUNK_W-1:0] chunks [NCH];
  logic [WLW-1:0]     words_loaded;
  logic [CW-1:0]      chunk_idx;
  logic [CW-1:0]      top_idx;
  logic               found;
  logic [DIGIT_W-1:0] rem;
  logic [POS_W-1:0]   position;

  logic [DIV_W-1:0]     dividend;
  logic [2*DIV_W-1:0]   product;
  logic [CHUNK_W-1:0]   quot;
  logic [DIGIT_W-1:0]   rem_new;
  logic                 quot_nz;
  logic                 pass_end;
  logic                 zero_now;
  logic                 room;
  logic [CW-1:0]        lo_idx;
  logic [CW-1:0]        hi_idx;

  // One 32-bit chunk of the long division per cycle, carrying the remainder
  // from the more significant chunk.
  assign dividend = {rem, chunks[chunk_idx]};
  assign product  = (2*DIV_W)'(dividend) * (2*DIV_W)'(RECIP);
  assign quot     = product[RECIP_SHIFT +: CHUNK_W];
  assign rem_new  = DIGIT_W'(dividend[DIGIT_W-1:0]
                    - ({quot[2:0], 1'b0} + {quot[0], 3'b000}));
  assign quot_nz  = (quot != '0);
  assign pass_end = (chunk_idx == '0);
  assign zero_now = pass_end && !found && !quot_nz;

  assign status.pass_end   = cmd.step && pass_end;
  assign status.value_zero = cmd.step && zero_now;

  assign room   = (words_loaded < WLW'(NUM_WORDS));
  assign lo_idx = CW'({words_loaded, 1'b0});
  assign hi_idx = CW'({words_loaded, 1'b1});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        chunks[i] <= '0;
      end
      words_loaded <= '0;
      chunk_idx    <= '0;
      top_idx      <= '0;
      found        <= 1'b0;
      rem          <= '0;
      position     <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= cmd.step && pass_end;
      if (cmd.load && room) begin
        chunks[lo_idx] <= word[CHUNK_W-1:0];
        chunks[hi_idx] <= word[WORD_W-1:CHUNK_W];
        words_loaded   <= words_loaded + 1'b1;
      end
      if (cmd.conv_start) begin
        chunk_idx <= CW'(NCH - 1);
        top_idx   <= '0;
        found     <= 1'b0;
        rem       <= '0;
        position  <= '0;
      end
      if (cmd.step) begin
        chunks[chunk_idx] <= quot;
        if (pass_end) begin
          // The next pass starts at the highest chunk whose quotient was
          // non-zero, so the passes shorten as the value shrinks.
          chunk_idx <= found ? top_idx : '0;
          found     <= 1'b0;
          rem       <= '0;
          position  <= position + 1'b1;
          if (zero_now) begin
            words_loaded <= '0;
          end
        end else begin
          chunk_idx <= chunk_idx - 1'b1;
          rem       <= rem_new;
          if (quot_nz && !found) begin
            found   <= 1'b1;
            top_idx <= chunk_idx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && pass_end) begin
      digit          <= rem_new;
      digit_position <= position;
      last_digit     <= zero_now;
    end
  end

endmodule

// ===== rtl/wide_binary_to_decimal.sv =====
`timescale 1ns / 1ps

// Converts an unsigned integer of NUM_WORDS 64-bit words, loaded least
// significant word first with one start pulse per word, into decimal digits
// sent least significant first. While non-final words load, busy
// stays low. The word marked last_word starts the conversion: each digit is
// one division pass by ten over the stored value, one 32-bit chunk per cycle
// through a single reciprocal multiplier, and a pass covers only the chunks
// that are still non-zero. The first pass always covers every chunk, and
// once the value fits in the lowest chunk each pass covers that chunk
// alone; a 128-bit store gives at most 39 digits. Each digit appears for
// one cycle with strobe high, in the cycle after its pass ends; the receiver
// cannot stall and must take it then. A zero value gives the single digit 0.
// Words beyond the capacity are dropped, though their last_word flag still
// starts the conversion.

module wide_binary_to_decimal
  import wbd_pkg::*;
#(
  parameter int NUM_WORDS = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [WORD_W-1:0]  word,
  input  logic               last_word,
  output logic               strobe,
  output logic [DIGIT_W-1:0] digit,
  output logic [POS_W-1:0]   digit_position,
  output logic               last_digit
);

  cmd_t    cmd;
  status_t status;

  wbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_word (last_word),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  wbd_datapath #(
    .NUM_WORDS (NUM_WORDS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .word           (word),
    .status         (status),
    .strobe         (strobe),
    .digit          (digit),
    .digit_position (digit_position),
    .last_digit     (last_digit)
  );

endmodule

// ===== dv/tb_wide_binary_to_decimal.sv =====
`timescale 1ns / 1ps

module tb_wide_binary_to_decimal;
  import wbd_pkg::*;

  localparam int NUM_WORDS    = 2;
  localparam int VALUE_W      = NUM_WORDS * WORD_W;
  localparam int DECIMAL_BASE = 10;
  localparam int RANDOM_WORDS = 500;
  localparam int CALM_TAIL    = 80;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              last;
  } load_word_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;
    logic               last;
  } dec_digit_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [WORD_W-1:0]  word = '0;
  logic               last_word = 1'b0;
  logic               strobe;
  logic [DIGIT_W-1:0] digit;
  logic [POS_W-1:0]   digit_position;
  logic               last_digit;

  load_word_t word_q[$];
  dec_digit_t pending_digits[$];

  // Own copy of the block's number store.
  logic [WORD_W-1:0] held_words[NUM_WORDS];
  int                held_count = 0;

  int n_offered  = 0;
  int n_accepted = 0;
  int gap_left   = 0;
  int errors     = 0;
  int total_words;

  wide_binary_to_decimal #(.NUM_WORDS(NUM_WORDS)) uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .word           (word),
    .last_word      (last_word),
    .strobe         (strobe),
    .digit          (digit),
    .digit_position (digit_position),
    .last_digit     (last_digit)
  );

  always #5 clk = ~clk;

  // Stores one accepted word and, on the last one, queues every decimal digit of the number.
  task automatic absorb_word(input logic [WORD_W-1:0] value, input logic last);
    logic [VALUE_W-1:0] acc;
    dec_digit_t         d;
    int                 pos;
    if (held_count < NUM_WORDS) begin
      held_words[held_count] = value;
      held_count++;
    end
    if (last) begin
      acc = '0;
      for (int i = 0; i < held_count; i++) acc[i*WORD_W +: WORD_W] = held_words[i];
      pos = 0;
      do begin
        d.digit = DIGIT_W'(acc % DECIMAL_BASE);
        acc     = acc / DECIMAL_BASE;
        d.pos   = POS_W'(pos);
        d.last  = (acc == 0);
        pending_digits.push_back(d);
        pos++;
      end while (acc != 0);
      held_count = 0;
    end
  endtask

  task automatic queue_word(input logic [WORD_W-1:0] value, input logic last);
    load_word_t w;
    w.value = value;
    w.last  = last;
    word_q.push_back(w);
  endtask

  // Splits a number into words, least significant first; extra words past the store are zero.
  task automatic queue_number(input logic [VALUE_W-1:0] value, input int n_words);
    for (int i = 0; i < n_words; i++)
      queue_word((i < NUM_WORDS) ? value[i*WORD_W +: WORD_W] : '0, i == n_words - 1);
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return WORD_W'($urandom_range(0, 1000));
      4:       return WORD_W'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(negedge clk) begin : drive_words
    load_word_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || n_accepted == n_offered) begin
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (word_q.size() != 0) begin
        nxt = word_q.pop_front();
        word      <= nxt.value;
        last_word <= nxt.last;
        start     <= 1'b1;
        n_offered++;
        if (word_q.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 8);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Digits are checked before a word taken on the same edge adds new expectations.
  always @(posedge clk) begin : watch_digits
    dec_digit_t want;
    if (!rst) begin
      if (strobe) begin
        if (pending_digits.size() == 0) begin
          $display("%0t: unexpected digit %0d pos %0d last %0b",
                   $time, digit, digit_position, last_digit);
          errors++;
        end else begin
          want = pending_digits.pop_front();
          if ({digit, digit_position, last_digit} !== want) begin
            $display("%0t: expected digit %0d pos %0d last %0b, got digit %0d pos %0d last %0b",
                     $time, want.digit, want.pos, want.last,
                     digit, digit_position, last_digit);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        absorb_word(word, last_word);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  initial begin
    int n_words;

    // Zero, in one word and in two.
    queue_word('0, 1'b1);
    queue_number('0, 2);
    // Small values around the digit boundaries.
    queue_number(VALUE_W'(9), 1);
    queue_number(VALUE_W'(10), 1);
    queue_number(VALUE_W'(99), 2);
    // Largest one-word and two-word values; the latter gives the full 39 digits.
    queue_word('1, 1'b1);
    queue_number('1, 2);
    // Ten to the 38th, the smallest 39-digit number, and two to the 64th.
    queue_number(128'h4B3B4CA8_5A86C47A_098A2240_00000000, 2);
    queue_word('0, 1'b0);
    queue_word(64'd1, 1'b1);
    // A leading zero word adds no digits.
    queue_word(64'd5, 1'b0);
    queue_word('0, 1'b1);
    // Words beyond the store are dropped, yet the flag on the last still starts conversion.
    queue_word(64'h0123_4567_89AB_CDEF, 1'b0);
    queue_word(64'hFEDC_BA98_7654_3210, 1'b0);
    queue_word('1, 1'b1);
    queue_word(64'h5555_5555_5555_5555, 1'b0);
    queue_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_word('1, 1'b0);
    queue_word(64'd7, 1'b1);

    while (word_q.size() < 19 + RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) n_words = $urandom_range(NUM_WORDS + 1, NUM_WORDS + 2);
      else                           n_words = $urandom_range(1, NUM_WORDS);
      for (int i = 0; i < n_words; i++)
        queue_word(random_word(), i == n_words - 1);
    end
    total_words = word_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (n_accepted != total_words) @(posedge clk);
    @(posedge clk);
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_digits.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0t: %0d mismatches, %0d digits never arrived",
               $time, errors, pending_digits.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timed out", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wbd_pkg.sv
rtl/wbd_ctrl.sv
rtl/wbd_datapath.sv
rtl/wide_binary_to_decimal.sv
dv/tb_wide_binary_to_decimal.sv
